// ----- design/ibc_pkg.sv -----
package ibc_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int AXES        = 6;
   localparam int AXIS_W      = 3;

   // Sum of up to 65535 raw counts, then the dividend of the bias average.
   localparam int SUM_W  = SAMPLE_BITS + 17;
   localparam int DIV_W  = SUM_W + 9;
   localparam int BIAS_W = DIV_W + 2;
   localparam int C_W    = BIAS_W + 1;
   localparam int HALF_W = 16;
   localparam int PROD_W = C_W + HALF_W + 1;
   localparam int ACC_W  = C_W + 33;
   localparam int STEP_W = $clog2(DIV_W + 1);

   localparam int CNT_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_SCALE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_SCALE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_COUNTS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YAW_OFFSET     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_SAMPLES  = 3'd4;

   localparam logic [31:0] ACCEL_SCALE_RESET   = 32'd20554396;
   localparam logic [31:0] GYRO_SCALE_RESET    = 32'd4575275;
   localparam logic [22:0] GRAVITY_RESET       = 23'd524288;
   localparam logic [CNT_W-1:0] CALIB_RESET    = 16'd2000;

   localparam logic [AXIS_W-1:0] AXIS_ACC_Z = 3'd2;
   localparam logic [AXIS_W-1:0] AXIS_GYR_X = 3'd3;
   localparam logic [AXIS_W-1:0] AXIS_GYR_Z = 3'd5;
   localparam logic [AXIS_W-1:0] AXIS_LAST  = 3'd5;

   // Temperature: round(raw * 400 / 207) + 6400, the division by 207 done by
   // a reciprocal multiply and one correction step.
   localparam int TX_W = 25;
   localparam int TQ_W = 18;
   localparam logic [TX_W-1:0] TEMP_RECIP = 25'd20748634;
   localparam logic [8:0]      TEMP_DIV   = 9'd207;
   localparam logic [8:0]      TEMP_GAIN  = 9'd400;
   localparam logic [6:0]      TEMP_HALF  = 7'd103;
   localparam logic [13:0]     TEMP_OFS   = 14'd6400;

   typedef struct packed {
      logic                          command;
      logic signed [15:0]            temp_raw;
      logic signed [SAMPLE_BITS-1:0] acc_x_raw;
      logic signed [SAMPLE_BITS-1:0] acc_y_raw;
      logic signed [SAMPLE_BITS-1:0] acc_z_raw;
      logic signed [SAMPLE_BITS-1:0] gyr_x_raw;
      logic signed [SAMPLE_BITS-1:0] gyr_y_raw;
      logic signed [SAMPLE_BITS-1:0] gyr_z_raw;
   } ibc_item_type;

   typedef struct packed {
      logic signed [31:0] acc_x_out;
      logic signed [31:0] acc_y_out;
      logic signed [31:0] acc_z_out;
      logic signed [31:0] gyr_x_out;
      logic signed [31:0] gyr_y_out;
      logic signed [31:0] gyr_z_out;
      logic signed [15:0] temp_out;
      logic               calibrating;
      logic               calib_done;
   } ibc_result_type;

   typedef struct packed {
      logic              load;
      logic              start;
      logic              mul_lo;
      logic              mul_hi;
      logic              temp_mul;
      logic              temp_fix;
      logic              accum;
      logic              div_load;
      logic              div_step;
      logic              div_store;
      logic              out_load;
      logic [AXIS_W-1:0] axis;
   } ibc_cmd_type;

   typedef struct packed {
      logic finish;
   } ibc_status_type;

endpackage

// ----- design/ibc_req_if.sv -----
interface ibc_req_if import ibc_pkg::*;;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic signed [15:0]            temp_raw;
   logic signed [SAMPLE_BITS-1:0] acc_x_raw;
   logic signed [SAMPLE_BITS-1:0] acc_y_raw;
   logic signed [SAMPLE_BITS-1:0] acc_z_raw;
   logic signed [SAMPLE_BITS-1:0] gyr_x_raw;
   logic signed [SAMPLE_BITS-1:0] gyr_y_raw;
   logic signed [SAMPLE_BITS-1:0] gyr_z_raw;

   modport source (output valid, command, temp_raw, acc_x_raw, acc_y_raw, acc_z_raw,
                   gyr_x_raw, gyr_y_raw, gyr_z_raw, input ready);
   modport sink (input valid, command, temp_raw, acc_x_raw, acc_y_raw, acc_z_raw,
                 gyr_x_raw, gyr_y_raw, gyr_z_raw, output ready);
endinterface

// ----- design/ibc_rsp_if.sv -----
interface ibc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] acc_x_out;
   logic signed [31:0] acc_y_out;
   logic signed [31:0] acc_z_out;
   logic signed [31:0] gyr_x_out;
   logic signed [31:0] gyr_y_out;
   logic signed [31:0] gyr_z_out;
   logic signed [15:0] temp_out;
   logic               calibrating;
   logic               calib_done;

   modport source (output valid, acc_x_out, acc_y_out, acc_z_out, gyr_x_out, gyr_y_out,
                   gyr_z_out, temp_out, calibrating, calib_done, input ready);
   modport sink (input valid, acc_x_out, acc_y_out, acc_z_out, gyr_x_out, gyr_y_out,
                 gyr_z_out, temp_out, calibrating, calib_done, output ready);
endinterface

// ----- design/ibc_datapath.sv -----
module ibc_datapath import ibc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  ibc_item_type          item,
   input  ibc_cmd_type           cmd,
   output ibc_status_type        status,
   output ibc_result_type        result
);

   logic [31:0]       accel_scale_ff;
   logic [31:0]       gyro_scale_ff;
   logic [22:0]       gravity_ff;
   logic signed [15:0] yaw_ff;
   logic [CNT_W-1:0]  calib_samples_ff;

   logic signed [SAMPLE_BITS-1:0] raw_ff [AXES];
   logic signed [15:0]            temp_raw_ff;
   logic signed [SUM_W-1:0]       sum_ff [AXES];
   logic signed [BIAS_W-1:0]      bias_ff [AXES];
   logic [CNT_W-1:0]              left_ff;
   logic                          in_cal_ff;
   logic                          done_ff;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [31:0]            res_ff [AXES];
   logic [TQ_W-1:0]               tq_ff;
   logic signed [15:0]            temp_res_ff;
   logic [DIV_W-1:0]              dvd_ff;
   logic [CNT_W-1:0]              rem_ff;
   logic                          neg_ff;
   ibc_result_type                result_ff;

   logic [CNT_W-1:0]         n_samples;
   logic [31:0]              scale;
   logic [HALF_W-1:0]        half;
   logic signed [C_W-1:0]    c_val;
   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  acc_sum;
   logic [ACC_W-56:0]        acc_top;
   logic signed [31:0]       sat_val;
   logic [16:0]              tmag;
   logic [TX_W-1:0]          tx;
   logic [2*TX_W-1:0]        tprod;
   logic [TX_W-1:0]          trem;
   logic [TQ_W-1:0]          tq_fix;
   logic signed [TQ_W+1:0]   tval;
   logic signed [SUM_W-1:0]  sum_sel;
   logic [DIV_W-1:0]         sum_mag;
   logic [CNT_W:0]           trial;
   logic                     trial_ge;
   logic signed [BIAS_W-1:0] qval;
   logic signed [BIAS_W-1:0] bias_new;

   assign n_samples = (calib_samples_ff == '0) ? CNT_W'(1) : calib_samples_ff;
   assign status.finish = in_cal_ff && (left_ff == CNT_W'(1));

   // Axis scaling: the 32-bit scale is applied in two 16-bit halves.
   assign scale = (cmd.axis < AXIS_GYR_X) ? accel_scale_ff : gyro_scale_ff;
   assign half  = cmd.mul_hi ? scale[31:16] : scale[15:0];
   assign c_val = (C_W'(raw_ff[cmd.axis]) <<< 8) - C_W'(bias_ff[cmd.axis]);
   assign prod  = c_val * $signed({1'b0, half});
   assign acc_sum = acc_ff + (ACC_W'(prod) <<< 16);
   assign acc_top = acc_sum[ACC_W-1:55];

   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         sat_val = acc_sum[55:24];
      end else if (acc_sum[ACC_W-1]) begin
         sat_val = 32'sh8000_0000;
      end else begin
         sat_val = 32'sh7fff_ffff;
      end
   end

   // Temperature path.
   assign tmag   = temp_raw_ff[15] ? 17'(-$signed({temp_raw_ff[15], temp_raw_ff}))
                                   : 17'(temp_raw_ff);
   assign tx     = TX_W'(tmag) * TX_W'(TEMP_GAIN) + TX_W'(TEMP_HALF);
   assign tprod  = (2*TX_W)'(tx) * (2*TX_W)'(TEMP_RECIP);
   assign trem   = tx - TX_W'(TX_W'(tq_ff) * TX_W'(TEMP_DIV));
   assign tq_fix = (trem >= TX_W'(TEMP_DIV)) ? tq_ff + TQ_W'(1) : tq_ff;
   assign tval   = (temp_raw_ff[15] ? -$signed({2'b00, tq_fix}) : $signed({2'b00, tq_fix}))
                   + $signed((TQ_W+2)'(TEMP_OFS));

   // Bias averaging divider, one quotient bit per cycle.
   assign sum_sel  = sum_ff[cmd.axis];
   assign sum_mag  = sum_sel[SUM_W-1] ? DIV_W'(-sum_sel) : DIV_W'(sum_sel);
   assign trial    = {rem_ff, dvd_ff[DIV_W-1]};
   assign trial_ge = trial >= {1'b0, n_samples};
   assign qval     = neg_ff ? -$signed(BIAS_W'(dvd_ff)) : $signed(BIAS_W'(dvd_ff));

   always_comb begin
      bias_new = qval;
      if (cmd.axis == AXIS_ACC_Z) begin
         bias_new = qval - $signed(BIAS_W'(gravity_ff));
      end else if (cmd.axis == AXIS_GYR_Z) begin
         bias_new = qval - (BIAS_W'(yaw_ff) <<< 8);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_scale_ff   <= ACCEL_SCALE_RESET;
         gyro_scale_ff    <= GYRO_SCALE_RESET;
         gravity_ff       <= GRAVITY_RESET;
         yaw_ff           <= '0;
         calib_samples_ff <= CALIB_RESET;
         left_ff          <= '0;
         in_cal_ff        <= 1'b0;
         done_ff          <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            sum_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_ACCEL_SCALE:    accel_scale_ff   <= csr_write_data;
               CSR_GYRO_SCALE:     gyro_scale_ff    <= csr_write_data;
               CSR_GRAVITY_COUNTS: gravity_ff       <= csr_write_data[22:0];
               CSR_YAW_OFFSET:     yaw_ff           <= csr_write_data[15:0];
               CSR_CALIB_SAMPLES:  calib_samples_ff <= csr_write_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            done_ff <= 1'b0;
         end
         if (cmd.start) begin
            for (int i = 0; i < AXES; i++) begin
               sum_ff[i] <= '0;
            end
            left_ff   <= n_samples;
            in_cal_ff <= 1'b1;
         end
         if (cmd.accum && in_cal_ff) begin
            for (int i = 0; i < AXES; i++) begin
               sum_ff[i] <= sum_ff[i] + SUM_W'(raw_ff[i]);
            end
            left_ff <= left_ff - CNT_W'(1);
            if (status.finish) begin
               in_cal_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
         if (cmd.div_store) begin
            bias_ff[cmd.axis] <= bias_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         temp_raw_ff <= item.temp_raw;
         raw_ff[0]   <= item.acc_x_raw;
         raw_ff[1]   <= item.acc_y_raw;
         raw_ff[2]   <= item.acc_z_raw;
         raw_ff[3]   <= item.gyr_x_raw;
         raw_ff[4]   <= item.gyr_y_raw;
         raw_ff[5]   <= item.gyr_z_raw;
      end
      if (cmd.mul_lo) begin
         acc_ff <= ACC_W'(prod) + ACC_W'(25'sd8388608);
      end
      if (cmd.mul_hi) begin
         res_ff[cmd.axis] <= sat_val;
      end
      if (cmd.temp_mul) begin
         tq_ff <= tprod[32 +: TQ_W];
      end
      if (cmd.temp_fix) begin
         if (tval > 20'sd32767) begin
            temp_res_ff <= 16'sh7fff;
         end else if (tval < -20'sd32768) begin
            temp_res_ff <= 16'sh8000;
         end else begin
            temp_res_ff <= tval[15:0];
         end
      end
      if (cmd.div_load) begin
         dvd_ff <= (sum_mag << 8) + DIV_W'(n_samples >> 1);
         rem_ff <= '0;
         neg_ff <= sum_sel[SUM_W-1];
      end
      if (cmd.div_step) begin
         rem_ff <= trial_ge ? CNT_W'(trial - {1'b0, n_samples}) : trial[CNT_W-1:0];
         dvd_ff <= {dvd_ff[DIV_W-2:0], trial_ge};
      end
      if (cmd.out_load) begin
         result_ff.acc_x_out   <= res_ff[0];
         result_ff.acc_y_out   <= res_ff[1];
         result_ff.acc_z_out   <= res_ff[2];
         result_ff.gyr_x_out   <= res_ff[3];
         result_ff.gyr_y_out   <= res_ff[4];
         result_ff.gyr_z_out   <= res_ff[5];
         result_ff.temp_out    <= temp_res_ff;
         result_ff.calibrating <= in_cal_ff;
         result_ff.calib_done  <= done_ff;
      end
   end

   assign result = result_ff;

endmodule

// ----- design/ibc_control.sv -----
module ibc_control import ibc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_command,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  ibc_status_type status,
   output ibc_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL_LO, S_MUL_HI, S_TEMP_MUL, S_TEMP_FIX, S_ACCUM,
      S_DIV_LOAD, S_DIV_STEP, S_DIV_STORE, S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.axis  = axis_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_command) begin
                  cmd.start = 1'b1;
               end else begin
                  axis_in  = '0;
                  state_in = S_MUL_LO;
               end
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               state_in = S_TEMP_MUL;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = S_MUL_LO;
            end
         end
         S_TEMP_MUL: begin
            cmd.temp_mul = 1'b1;
            state_in     = S_TEMP_FIX;
         end
         S_TEMP_FIX: begin
            cmd.temp_fix = 1'b1;
            state_in     = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            if (status.finish) begin
               axis_in  = '0;
               state_in = S_DIV_LOAD;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = S_DIV_STEP;
         end
         S_DIV_STEP: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               state_in = S_DIV_STORE;
            end
         end
         S_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (axis_ff == AXIS_LAST) begin
               state_in = S_OUT;
            end else begin
               axis_in  = axis_ff + AXIS_W'(1);
               state_in = S_DIV_LOAD;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The result register is only overwritten once its previous transfer is done.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STEP) |-> (step_ff < STEP_W'(DIV_W)))
      else $error("divider step count out of range");

   a_cmd_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && req_command) |=> (state_ff == S_IDLE))
      else $error("start command left the idle state");

   a_div_axis: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_STORE) |-> (axis_ff <= AXIS_LAST))
      else $error("divider axis out of range");

endmodule

// ----- design/imu_bias_calibrate_scale.sv -----
// Six-axis IMU sample scaler with static bias calibration. A sample item
// (command 0) gives one result after the accept state, a low-half and a
// high-half step per axis on the shared 45x17 multiplier, the temperature
// reciprocal multiply and correction, the accumulate state and the load
// of the output register. A start-calibration item (command 1) is taken
// in the accept state and gives no result. The sample that completes a
// calibration also runs the bit-serial bias divider (per axis a load, a
// quotient bit per step, a store). One item is worked on at a time; a
// finished result waits in the output register while the next is accepted.
module imu_bias_calibrate_scale import ibc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   ibc_req_if.sink               req_ch,
   ibc_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   ibc_item_type   item;
   ibc_result_type result;
   ibc_cmd_type    cmd;
   ibc_status_type status;

   assign item.command   = req_ch.command;
   assign item.temp_raw  = req_ch.temp_raw;
   assign item.acc_x_raw = req_ch.acc_x_raw;
   assign item.acc_y_raw = req_ch.acc_y_raw;
   assign item.acc_z_raw = req_ch.acc_z_raw;
   assign item.gyr_x_raw = req_ch.gyr_x_raw;
   assign item.gyr_y_raw = req_ch.gyr_y_raw;
   assign item.gyr_z_raw = req_ch.gyr_z_raw;

   ibc_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   ibc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .cmd              (cmd),
      .status           (status),
      .result           (result)
   );

   assign rsp_ch.acc_x_out   = result.acc_x_out;
   assign rsp_ch.acc_y_out   = result.acc_y_out;
   assign rsp_ch.acc_z_out   = result.acc_z_out;
   assign rsp_ch.gyr_x_out   = result.gyr_x_out;
   assign rsp_ch.gyr_y_out   = result.gyr_y_out;
   assign rsp_ch.gyr_z_out   = result.gyr_z_out;
   assign rsp_ch.temp_out    = result.temp_out;
   assign rsp_ch.calibrating = result.calibrating;
   assign rsp_ch.calib_done  = result.calib_done;

endmodule

// ----- sim/tb_if.sv -----
// The block's channel interfaces are compiled from the design folder; this file adds
// the CSR write port bundle used by the testbench drivers.
interface tb_csr_if import ibc_pkg::*;;
   logic                  write_enable;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output write_enable, index, write_data);
   modport sink (input write_enable, index, write_data);
endinterface

// ----- sim/tb_top.sv -----
module tb_top;
   import ibc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 20000;
   localparam int CALIB_WAIT = 400;

   // Predicts the sample results from its own copy of the bias state and the registers.
   class imu_result_tracker;
      logic [31:0] accel_scale, gyro_scale;
      logic [22:0] gravity_counts;
      logic signed [15:0] yaw_offset;
      logic [15:0] calib_samples;
      longint axis_sum[6];
      longint axis_bias[6];
      logic [15:0] samples_left;
      bit collecting;
      ibc_result_type pending[$];
      int errors;

      function new();
         accel_scale = ACCEL_SCALE_RESET;
         gyro_scale = GYRO_SCALE_RESET;
         gravity_counts = GRAVITY_RESET;
         yaw_offset = 0;
         calib_samples = CALIB_RESET;
         foreach (axis_sum[i]) begin
            axis_sum[i] = 0;
            axis_bias[i] = 0;
         end
         samples_left = 0;
         collecting = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
         case (idx)
            CSR_ACCEL_SCALE: accel_scale = v;
            CSR_GYRO_SCALE: gyro_scale = v;
            CSR_GRAVITY_COUNTS: gravity_counts = v[22:0];
            CSR_YAW_OFFSET: yaw_offset = v[15:0];
            CSR_CALIB_SAMPLES: calib_samples = v[15:0];
            default: ;
         endcase
      endfunction

      function longint round_div(longint n, longint d);
         longint mag;
         mag = (n < 0) ? -n : n;
         mag = (mag + d / 2) / d;
         return (n < 0) ? -mag : mag;
      endfunction

      function logic [31:0] scaled_axis(longint c, logic [31:0] s);
         logic signed [127:0] p;
         p = (128'(signed'(c)) * $signed({96'd0, s}) + (128'sd1 << 23)) >>> 24;
         if (p > 128'sd2147483647) return 32'h7fffffff;
         if (p < -128'sd2147483648) return 32'h80000000;
         return p[31:0];
      endfunction

      function longint eff_count();
         return (calib_samples == 0) ? 1 : calib_samples;
      endfunction

      function void note_item(ibc_item_type it);
         longint raw[6];
         longint t;
         ibc_result_type r;
         logic [31:0] o[6];
         if (it.command) begin
            foreach (axis_sum[i]) axis_sum[i] = 0;
            samples_left = eff_count();
            collecting = 1;
            return;
         end
         raw[0] = it.acc_x_raw; raw[1] = it.acc_y_raw; raw[2] = it.acc_z_raw;
         raw[3] = it.gyr_x_raw; raw[4] = it.gyr_y_raw; raw[5] = it.gyr_z_raw;
         for (int i = 0; i < 6; i++)
            o[i] = scaled_axis(raw[i] * 256 - axis_bias[i], i < 3 ? accel_scale : gyro_scale);
         r.acc_x_out = o[0]; r.acc_y_out = o[1]; r.acc_z_out = o[2];
         r.gyr_x_out = o[3]; r.gyr_y_out = o[4]; r.gyr_z_out = o[5];
         t = round_div(longint'(it.temp_raw) * 400, 207) + 6400;
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         r.temp_out = t[15:0];
         r.calib_done = 0;
         if (collecting) begin
            for (int i = 0; i < 6; i++) axis_sum[i] += raw[i];
            samples_left = samples_left - 1;
            if (samples_left == 0) begin
               for (int i = 0; i < 6; i++)
                  axis_bias[i] = round_div(axis_sum[i] * 256, eff_count());
               axis_bias[2] -= longint'(gravity_counts);
               axis_bias[5] -= longint'(yaw_offset) * 256;
               collecting = 0;
               r.calib_done = 1;
            end
         end
         r.calibrating = collecting;
         pending.push_back(r);
      endfunction

      function void check_result(ibc_result_type got);
         ibc_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.acc_x_out !== want.acc_x_out)
            $display("%0t: acc_x exp %h got %h", $realtime, want.acc_x_out, got.acc_x_out);
         if (got.acc_y_out !== want.acc_y_out)
            $display("%0t: acc_y exp %h got %h", $realtime, want.acc_y_out, got.acc_y_out);
         if (got.acc_z_out !== want.acc_z_out)
            $display("%0t: acc_z exp %h got %h", $realtime, want.acc_z_out, got.acc_z_out);
         if (got.gyr_x_out !== want.gyr_x_out)
            $display("%0t: gyr_x exp %h got %h", $realtime, want.gyr_x_out, got.gyr_x_out);
         if (got.gyr_y_out !== want.gyr_y_out)
            $display("%0t: gyr_y exp %h got %h", $realtime, want.gyr_y_out, got.gyr_y_out);
         if (got.gyr_z_out !== want.gyr_z_out)
            $display("%0t: gyr_z exp %h got %h", $realtime, want.gyr_z_out, got.gyr_z_out);
         if (got.temp_out !== want.temp_out)
            $display("%0t: temp exp %h got %h", $realtime, want.temp_out, got.temp_out);
         if (got.calibrating !== want.calibrating)
            $display("%0t: calibrating exp %b got %b", $realtime, want.calibrating,
                     got.calibrating);
         if (got.calib_done !== want.calib_done)
            $display("%0t: calib_done exp %b got %b", $realtime, want.calib_done,
                     got.calib_done);
         if (got !== want) errors++;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   ibc_req_if req_ch();
   ibc_rsp_if rsp_ch();
   tb_csr_if csr();

   imu_bias_calibrate_scale dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_write_enable(csr.write_enable), .csr_index(csr.index),
      .csr_write_data(csr.write_data)
   );

   imu_result_tracker tracker = new();
   int hold_off = 0;     // long receiver stall, in cycles
   bit sink_busy = 0;    // flag that nothing sets or reads
   int quiet = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      req_ch.valid = 0;
      req_ch.command = 0;
      req_ch.temp_raw = 0;
      req_ch.acc_x_raw = 0; req_ch.acc_y_raw = 0; req_ch.acc_z_raw = 0;
      req_ch.gyr_x_raw = 0; req_ch.gyr_y_raw = 0; req_ch.gyr_z_raw = 0;
      rsp_ch.ready = 0;
      csr.write_enable = 0;
      csr.index = 0;
      csr.write_data = 0;
   end

   // Result side: samples at the rising edge, moves ready at the falling edge.
   initial begin : receiver
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_result({rsp_ch.acc_x_out, rsp_ch.acc_y_out, rsp_ch.acc_z_out,
                                  rsp_ch.gyr_x_out, rsp_ch.gyr_y_out, rsp_ch.gyr_z_out,
                                  rsp_ch.temp_out, rsp_ch.calibrating, rsp_ch.calib_done});
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         end
         @(negedge clock);
         if (hold_off > 0) begin
            hold_off--;
            rsp_ch.ready <= 0;
         end else if (gap > 0) begin
            gap--;
            rsp_ch.ready <= 0;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Driven with blocking assignments at the falling edge, so that an item that
   // follows with no gap can raise valid in the step that lowered it.
   task automatic send_item(ibc_item_type it, bit idle_ok);
      int pause;
      pause = idle_ok ? $urandom_range(0, 11) : 0;
      repeat (pause) @(negedge clock);
      req_ch.valid = 1;
      req_ch.command = it.command;
      req_ch.temp_raw = it.temp_raw;
      req_ch.acc_x_raw = it.acc_x_raw;
      req_ch.acc_y_raw = it.acc_y_raw;
      req_ch.acc_z_raw = it.acc_z_raw;
      req_ch.gyr_x_raw = it.gyr_x_raw;
      req_ch.gyr_y_raw = it.gyr_y_raw;
      req_ch.gyr_z_raw = it.gyr_z_raw;
      do @(posedge clock); while (!req_ch.ready);
      tracker.note_item(it);
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   task automatic drain();
      while (tracker.pending.size() != 0) @(negedge clock);
      // Leave the block idle for a while before the registers change.
      repeat (CALIB_WAIT) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] v);
      @(negedge clock);
      csr.write_enable <= 1;
      csr.index <= idx;
      csr.write_data <= v;
      tracker.write_reg(idx, v);
      @(negedge clock);
      csr.write_enable <= 0;
   endtask

   function automatic ibc_item_type random_sample();
      ibc_item_type it;
      it = {$urandom, $urandom, $urandom, $urandom};
      it.command = 0;
      // Favor small acc_x and gyr_z counts so biased values stay in range most of the time.
      if ($urandom_range(0, 3) != 0) begin
         it.acc_x_raw = $signed(16'($urandom_range(0, 4000))) - 2000;
         it.gyr_z_raw = $signed(16'($urandom_range(0, 4000))) - 2000;
      end
      return it;
   endfunction

   function automatic ibc_item_type filled(logic cmd, logic [15:0] v);
      ibc_item_type it;
      it.command = cmd;
      it.temp_raw = v;
      it.acc_x_raw = v; it.acc_y_raw = v; it.acc_z_raw = v;
      it.gyr_x_raw = v; it.gyr_y_raw = v; it.gyr_z_raw = v;
      return it;
   endfunction

   task automatic calibration_run(int n, bit idle_ok);
      send_item(filled(1'b1, 16'($urandom)), idle_ok);
      for (int k = 0; k < n; k++) send_item(random_sample(), idle_ok);
   endtask

   initial begin : stimulus
      int sent;
      logic [15:0] edge_vals[5];
      edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: field extremes at reset scales, then full-range scales.
      foreach (edge_vals[i]) send_item(filled(1'b0, edge_vals[i]), 0);
      drain();
      write_reg(CSR_ACCEL_SCALE, 32'hffffffff);
      write_reg(CSR_GYRO_SCALE, 32'h00000000);
      write_reg(CSR_CALIB_SAMPLES, 16'd0);       // zero count acts as one
      write_reg(CSR_GRAVITY_COUNTS, 23'h7fffff);
      write_reg(CSR_YAW_OFFSET, 16'h8000);
      write_reg(3'd7, 32'hdeadbeef);             // unmapped index is dropped
      foreach (edge_vals[i]) send_item(filled(1'b0, edge_vals[i]), 0);
      send_item(filled(1'b1, 16'h1234), 0);
      send_item(filled(1'b0, 16'h7fff), 0);      // finishes calibration
      send_item(filled(1'b0, 16'h8000), 0);      // uses the new biases
      drain();
      write_reg(CSR_CALIB_SAMPLES, 16'd3);
      write_reg(CSR_YAW_OFFSET, 16'h7fff);
      write_reg(CSR_GRAVITY_COUNTS, 23'd0);
      write_reg(CSR_GYRO_SCALE, 32'hffffffff);
      send_item(filled(1'b1, 16'h0), 0);
      send_item(filled(1'b0, 16'h8000), 0);
      send_item(filled(1'b1, 16'h0), 0);         // restart while collecting
      for (int k = 0; k < 4; k++) send_item(filled(1'b0, 16'h8001 + k), 0);
      drain();
      write_reg(CSR_ACCEL_SCALE, ACCEL_SCALE_RESET);
      write_reg(CSR_GYRO_SCALE, GYRO_SCALE_RESET);
      write_reg(CSR_GRAVITY_COUNTS, GRAVITY_RESET);
      write_reg(CSR_YAW_OFFSET, 16'd50);

      // Random phases, each with its own register setting.
      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_CALIB_SAMPLES, $urandom_range(1, 12));
         if (phase % 2 == 1) write_reg(CSR_ACCEL_SCALE, $urandom);
         if (phase % 3 == 2) write_reg(CSR_GYRO_SCALE, $urandom);
         if (phase == 5) write_reg(CSR_CALIB_SAMPLES, 16'hffff);
         if (phase == 3) begin
            // Long receiver stall with items still offered, then a full pause.
            hold_off = 300;
            for (int k = 0; k < 10; k++) send_item(random_sample(), 0);
            sent += 10;
            drain();
         end
         while (sent < (phase + 1) * 115) begin
            case ($urandom_range(0, 9))
               0: begin
                  send_item(filled(1'b1, 16'($urandom)), 1);
                  sent++;
               end
               1, 2: begin
                  calibration_run($urandom_range(1, 14), $urandom_range(0, 1));
                  sent += 8;
               end
               default: begin
                  send_item(random_sample(), $urandom_range(0, 2) != 0);
                  sent++;
               end
            endcase
         end
         drain();
         write_reg(CSR_GRAVITY_COUNTS, $urandom_range(0, 23'h7fffff));
         write_reg(CSR_YAW_OFFSET, $urandom);
      end

      drain();
      if (tracker.errors == 0 && tracker.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
